/* rtl/cotw_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Triangle cotangent weights: shared definitions
// Widths of the datapath, result limits, status codes and the word types that
// move between the geometry, square root and divider sections.
// ----------------------------------------------------------------------------
package cotw_pkg;

  localparam int COORD_WIDTH   = 24;
  localparam int OUT_WIDTH     = 32;
  localparam int OUT_FRAC_BITS = 16;
  localparam int TAG_WIDTH     = 16;

  localparam int DW   = COORD_WIDTH + 1;
  localparam int PW   = 2 * DW;
  localparam int LW   = 2 * DW + 1;
  localparam int NW   = LW + 2;
  localparam int KW   = 2 * DW + 1;
  localparam int KMW  = 2 * DW;
  localparam int SW   = 4 * DW + 2;
  localparam int RW   = SW / 2;
  localparam int DENW = RW + 1;
  localparam int RMW  = DENW + 1;
  localparam int LOWW = OUT_WIDTH - OUT_FRAC_BITS;
  localparam int ZW   = NW + DENW + LOWW;

  localparam int GEOM_STAGES = 7;
  localparam int LANES       = 3;

  localparam logic [OUT_WIDTH-1:0] MAX_POS = {1'b0, {(OUT_WIDTH-1){1'b1}}};
  localparam logic [OUT_WIDTH-1:0] MIN_MAG = {1'b1, {(OUT_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SAT   = 2'd1,
    ST_DEGEN = 2'd2
  } status_t;

  typedef struct packed {
    logic [TAG_WIDTH-1:0]        tag;
    logic                        zero;
    logic [LANES-1:0][NW-1:0]    num;
  } side_t;

  typedef struct packed {
    logic [OUT_WIDTH-1:0] q;
    logic                 neg;
    logic                 ovf;
  } lane_t;

endpackage
`default_nettype wire

/* rtl/cotw_geom.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Triangle cotangent weights: geometry section
// Edge vectors, squared edge lengths, cotangent numerators and the squared
// norm of the cross product, over seven register stages.
// ----------------------------------------------------------------------------
module cotw_geom import cotw_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_v,
  input  wire logic [TAG_WIDTH-1:0]          tag,
  input  wire logic signed [COORD_WIDTH-1:0] ax,
  input  wire logic signed [COORD_WIDTH-1:0] ay,
  input  wire logic signed [COORD_WIDTH-1:0] az,
  input  wire logic signed [COORD_WIDTH-1:0] bx,
  input  wire logic signed [COORD_WIDTH-1:0] by_coord,
  input  wire logic signed [COORD_WIDTH-1:0] bz,
  input  wire logic signed [COORD_WIDTH-1:0] cx,
  input  wire logic signed [COORD_WIDTH-1:0] cy,
  input  wire logic signed [COORD_WIDTH-1:0] cz,
  output logic                               out_v,
  output logic [SW-1:0]                      s,
  output side_t                              side
);

  function automatic logic signed [DW-1:0] diff(input logic signed [COORD_WIDTH-1:0] p,
                                                input logic signed [COORD_WIDTH-1:0] q);
    return DW'(p) - DW'(q);
  endfunction

  logic [GEOM_STAGES-1:0] vld_r;
  logic [TAG_WIDTH-1:0]   tag_r [GEOM_STAGES];

  logic signed [DW-1:0]  u_r [3];
  logic signed [DW-1:0]  v_r [3];
  logic signed [DW-1:0]  w_r [3];
  logic signed [PW-1:0]  squ_r [3];
  logic signed [PW-1:0]  sqv_r [3];
  logic signed [PW-1:0]  sqw_r [3];
  logic signed [PW-1:0]  cp_r [6];
  logic [LW-1:0]         a2_r, b2_r, c2_r;
  logic signed [KW-1:0]  k_r [3];
  logic [LANES-1:0][NW-1:0] num4_r, num5_r, num6_r, num7_r;
  logic [KMW-1:0]        km_r [3];
  logic [PW-1:0]         phh_r [3];
  logic [PW-1:0]         phl_r [3];
  logic [PW-1:0]         pll_r [3];
  logic [SW-1:0]         ksq_r [3];
  logic [SW-1:0]         s_r;
  logic                  zero_r;

  logic [LANES-1:0][NW-1:0] num_nxt;
  logic [KMW-1:0]        km_nxt [3];
  logic [SW-1:0]         ksq_nxt [3];

  always_comb begin
    num_nxt[0] = NW'(b2_r) + NW'(c2_r) - NW'(a2_r);
    num_nxt[1] = NW'(c2_r) + NW'(a2_r) - NW'(b2_r);
    num_nxt[2] = NW'(a2_r) + NW'(b2_r) - NW'(c2_r);
    for (int i = 0; i < 3; i++) begin
      km_nxt[i]  = k_r[i][KW-1] ? KMW'(-k_r[i]) : KMW'(k_r[i]);
      ksq_nxt[i] = (SW'(phh_r[i]) << (2 * DW)) + (SW'(phl_r[i]) << (DW + 1))
                   + SW'(pll_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[GEOM_STAGES-2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0] <= tag;
      for (int i = 1; i < GEOM_STAGES; i++) begin
        tag_r[i] <= tag_r[i-1];
      end
      u_r[0] <= diff(bx, ax);
      u_r[1] <= diff(by_coord, ay);
      u_r[2] <= diff(bz, az);
      v_r[0] <= diff(cx, ax);
      v_r[1] <= diff(cy, ay);
      v_r[2] <= diff(cz, az);
      w_r[0] <= diff(bx, cx);
      w_r[1] <= diff(by_coord, cy);
      w_r[2] <= diff(bz, cz);
      for (int i = 0; i < 3; i++) begin
        squ_r[i] <= u_r[i] * u_r[i];
        sqv_r[i] <= v_r[i] * v_r[i];
        sqw_r[i] <= w_r[i] * w_r[i];
      end
      cp_r[0] <= u_r[1] * v_r[2];
      cp_r[1] <= u_r[2] * v_r[1];
      cp_r[2] <= u_r[2] * v_r[0];
      cp_r[3] <= u_r[0] * v_r[2];
      cp_r[4] <= u_r[0] * v_r[1];
      cp_r[5] <= u_r[1] * v_r[0];
      a2_r <= LW'($unsigned(sqw_r[0])) + LW'($unsigned(sqw_r[1]))
              + LW'($unsigned(sqw_r[2]));
      b2_r <= LW'($unsigned(sqv_r[0])) + LW'($unsigned(sqv_r[1]))
              + LW'($unsigned(sqv_r[2]));
      c2_r <= LW'($unsigned(squ_r[0])) + LW'($unsigned(squ_r[1]))
              + LW'($unsigned(squ_r[2]));
      for (int i = 0; i < 3; i++) begin
        k_r[i] <= KW'(cp_r[2*i]) - KW'(cp_r[2*i+1]);
      end
      num4_r <= num_nxt;
      for (int i = 0; i < 3; i++) begin
        km_r[i]  <= km_nxt[i];
        phh_r[i] <= km_r[i][KMW-1:DW] * km_r[i][KMW-1:DW];
        phl_r[i] <= km_r[i][KMW-1:DW] * km_r[i][DW-1:0];
        pll_r[i] <= km_r[i][DW-1:0] * km_r[i][DW-1:0];
        ksq_r[i] <= ksq_nxt[i];
      end
      num5_r <= num4_r;
      num6_r <= num5_r;
      num7_r <= num6_r;
      s_r    <= ksq_r[0] + ksq_r[1] + ksq_r[2];
      zero_r <= ((ksq_r[0] | ksq_r[1] | ksq_r[2]) == '0);
    end
  end

  assign out_v     = vld_r[GEOM_STAGES-1];
  assign s         = s_r;
  assign side.tag  = tag_r[GEOM_STAGES-1];
  assign side.zero = zero_r;
  assign side.num  = num7_r;

endmodule
`default_nettype wire

/* rtl/cotw_sqrt.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Triangle cotangent weights: integer square root
// Digit-by-digit square root, one root bit per register stage, with the side
// word carried alongside.
// ----------------------------------------------------------------------------
module cotw_sqrt import cotw_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_v,
  input  wire logic [SW-1:0] s,
  input  wire side_t         side_in,
  output logic               out_v,
  output logic [RW-1:0]      root,
  output side_t              side_out
);

  logic [RW-1:0] vld_r;
  logic [RW:0]   rem_r  [RW];
  logic [RW-1:0] root_r [RW];
  logic [SW-1:0] rad_r  [RW];
  side_t         sd_r   [RW];

  logic [RW:0]   rem_nxt  [RW];
  logic [RW-1:0] root_nxt [RW];
  logic [SW-1:0] rad_nxt  [RW];
  side_t         sd_nxt   [RW];
  logic [RW-1:0] vld_nxt;

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic [RW:0]   rem_in;
    logic [RW-1:0] root_in;
    logic [SW-1:0] rad_in;
    logic [RW+1:0] rem_t;
    logic [RW+1:0] trial;
    logic          ge;
    if (i == 0) begin : g_first
      assign rem_in     = '0;
      assign root_in    = '0;
      assign rad_in     = s;
      assign sd_nxt[i]  = side_in;
      assign vld_nxt[i] = in_v;
    end else begin : g_next
      assign rem_in     = rem_r[i-1];
      assign root_in    = root_r[i-1];
      assign rad_in     = rad_r[i-1];
      assign sd_nxt[i]  = sd_r[i-1];
      assign vld_nxt[i] = vld_r[i-1];
    end
    assign rem_t       = {rem_in[RW-1:0], rad_in[SW-1 -: 2]};
    assign trial       = {root_in, 2'b01};
    assign ge          = (rem_t >= trial);
    assign rem_nxt[i]  = ge ? (RW+1)'(rem_t - trial) : rem_t[RW:0];
    assign root_nxt[i] = {root_in[RW-2:0], ge};
    assign rad_nxt[i]  = rad_in << 2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < RW; i++) begin
        rem_r[i]  <= rem_nxt[i];
        root_r[i] <= root_nxt[i];
        rad_r[i]  <= rad_nxt[i];
        sd_r[i]   <= sd_nxt[i];
      end
    end
  end

  assign out_v    = vld_r[RW-1];
  assign root     = root_r[RW-1];
  assign side_out = sd_r[RW-1];

  // The final remainder never exceeds twice the root.
  assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[RW-1] |-> (rem_r[RW-1] <= {root_r[RW-1], 1'b0}))
    else $error("square root remainder out of bound");

endmodule
`default_nettype wire

/* rtl/cotw_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Triangle cotangent weights: scaled dividers
// Three restoring dividers in lockstep, one quotient bit per register stage,
// after a stage that takes magnitudes and detects quotient overflow.
// ----------------------------------------------------------------------------
module cotw_div import cotw_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_v,
  input  wire logic [RW-1:0]    root,
  input  wire side_t            side_in,
  output logic                  out_v,
  output logic [TAG_WIDTH-1:0]  tag_out,
  output logic                  zero_out,
  output lane_t [LANES-1:0]     res
);

  localparam int DS = OUT_WIDTH;

  logic                  pv_r;
  logic [DENW-1:0]       pden_r;
  logic [TAG_WIDTH-1:0]  ptag_r;
  logic                  pzero_r;
  logic [RMW-1:0]        prem_r [LANES];
  logic [OUT_WIDTH-1:0]  plow_r [LANES];
  logic [LANES-1:0]      pneg_r, povf_r;

  logic [DENW-1:0]       den_nxt;
  logic [NW-1:0]         mag_nxt [LANES];
  logic [LANES-1:0]      neg_nxt, ovf_nxt;

  always_comb begin
    den_nxt = {root, 1'b0};
    for (int l = 0; l < LANES; l++) begin
      neg_nxt[l] = side_in.num[l][NW-1];
      mag_nxt[l] = neg_nxt[l] ? NW'(-side_in.num[l]) : side_in.num[l];
      ovf_nxt[l] = (ZW'(mag_nxt[l]) >= (ZW'(den_nxt) << LOWW));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (en) begin
      pv_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pden_r  <= den_nxt;
      ptag_r  <= side_in.tag;
      pzero_r <= side_in.zero;
      pneg_r  <= neg_nxt;
      povf_r  <= ovf_nxt;
      for (int l = 0; l < LANES; l++) begin
        prem_r[l] <= RMW'(mag_nxt[l] >> LOWW);
        plow_r[l] <= OUT_WIDTH'(mag_nxt[l]) << OUT_FRAC_BITS;
      end
    end
  end

  logic [DS-1:0]         vld_r;
  logic [DENW-1:0]       den_r  [DS];
  logic [TAG_WIDTH-1:0]  tag_r  [DS];
  logic [DS-1:0]         zero_r;
  logic [LANES-1:0]      neg_r  [DS];
  logic [LANES-1:0]      ovf_r  [DS];
  logic [RMW-1:0]        rem_r  [DS][LANES];
  logic [OUT_WIDTH-1:0]  q_r    [DS][LANES];
  logic [OUT_WIDTH-1:0]  low_r  [DS][LANES];

  logic [DS-1:0]         vld_nxt;
  logic [DENW-1:0]       dn_nxt  [DS];
  logic [TAG_WIDTH-1:0]  tg_nxt  [DS];
  logic [DS-1:0]         zr_nxt;
  logic [LANES-1:0]      ng_nxt  [DS];
  logic [LANES-1:0]      of_nxt  [DS];
  logic [RMW-1:0]        rem_nxt [DS][LANES];
  logic [OUT_WIDTH-1:0]  q_nxt   [DS][LANES];
  logic [OUT_WIDTH-1:0]  low_nxt [DS][LANES];

  for (genvar j = 0; j < DS; j++) begin : g_stage
    logic [DENW-1:0] den_in;
    if (j == 0) begin : g_first
      assign den_in     = pden_r;
      assign vld_nxt[j] = pv_r;
      assign tg_nxt[j]  = ptag_r;
      assign zr_nxt[j]  = pzero_r;
      assign ng_nxt[j]  = pneg_r;
      assign of_nxt[j]  = povf_r;
    end else begin : g_next
      assign den_in     = den_r[j-1];
      assign vld_nxt[j] = vld_r[j-1];
      assign tg_nxt[j]  = tag_r[j-1];
      assign zr_nxt[j]  = zero_r[j-1];
      assign ng_nxt[j]  = neg_r[j-1];
      assign of_nxt[j]  = ovf_r[j-1];
    end
    assign dn_nxt[j] = den_in;
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [RMW-1:0]       rem_in, rem_t;
      logic [OUT_WIDTH-1:0] q_in, low_in;
      logic                 ge;
      if (j == 0) begin : g_first
        assign rem_in = prem_r[l];
        assign q_in   = '0;
        assign low_in = plow_r[l];
      end else begin : g_next
        assign rem_in = rem_r[j-1][l];
        assign q_in   = q_r[j-1][l];
        assign low_in = low_r[j-1][l];
      end
      assign rem_t         = {rem_in[RMW-2:0], low_in[OUT_WIDTH-1]};
      assign ge            = (rem_t >= RMW'(den_in));
      assign rem_nxt[j][l] = ge ? (rem_t - RMW'(den_in)) : rem_t;
      assign q_nxt[j][l]   = {q_in[OUT_WIDTH-2:0], ge};
      assign low_nxt[j][l] = low_in << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r <= zr_nxt;
      for (int j = 0; j < DS; j++) begin
        den_r[j] <= dn_nxt[j];
        tag_r[j] <= tg_nxt[j];
        neg_r[j] <= ng_nxt[j];
        ovf_r[j] <= of_nxt[j];
        for (int l = 0; l < LANES; l++) begin
          rem_r[j][l] <= rem_nxt[j][l];
          q_r[j][l]   <= q_nxt[j][l];
          low_r[j][l] <= low_nxt[j][l];
        end
      end
    end
  end

  assign out_v    = vld_r[DS-1];
  assign tag_out  = tag_r[DS-1];
  assign zero_out = zero_r[DS-1];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      res[l].q   = q_r[DS-1][l];
      res[l].neg = neg_r[DS-1][l];
      res[l].ovf = ovf_r[DS-1][l];
    end
  end

endmodule
`default_nettype wire

/* rtl/triangle_cotangent_weights_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Triangle cotangent weights: top level
// Input words pass in order through the geometry, square root, divider and
// output register sections to their result words.
// Throughput: one triangle per cycle; the whole pipeline holds while a result
// word waits under stall.
// Reset clears every valid bit; payload registers are not reset.
// ----------------------------------------------------------------------------
module triangle_cotangent_weights_top import cotw_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [TAG_WIDTH-1:0]          in_face_index,
  input  wire logic signed [COORD_WIDTH-1:0] in_ax,
  input  wire logic signed [COORD_WIDTH-1:0] in_ay,
  input  wire logic signed [COORD_WIDTH-1:0] in_az,
  input  wire logic signed [COORD_WIDTH-1:0] in_bx,
  input  wire logic signed [COORD_WIDTH-1:0] in_by_coord,
  input  wire logic signed [COORD_WIDTH-1:0] in_bz,
  input  wire logic signed [COORD_WIDTH-1:0] in_cx,
  input  wire logic signed [COORD_WIDTH-1:0] in_cy,
  input  wire logic signed [COORD_WIDTH-1:0] in_cz,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [TAG_WIDTH-1:0]               out_face_index_out,
  output logic signed [OUT_WIDTH-1:0]        out_cot_a,
  output logic signed [OUT_WIDTH-1:0]        out_cot_b,
  output logic signed [OUT_WIDTH-1:0]        out_cot_c,
  output logic [1:0]                         out_status
);

  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  logic          g_v;
  logic [SW-1:0] g_s;
  side_t         g_side;

  cotw_geom u_geom (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (in_valid),
    .tag      (in_face_index),
    .ax       (in_ax),
    .ay       (in_ay),
    .az       (in_az),
    .bx       (in_bx),
    .by_coord (in_by_coord),
    .bz       (in_bz),
    .cx       (in_cx),
    .cy       (in_cy),
    .cz       (in_cz),
    .out_v    (g_v),
    .s        (g_s),
    .side     (g_side)
  );

  logic          r_v;
  logic [RW-1:0] r_root;
  side_t         r_side;

  cotw_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (g_v),
    .s        (g_s),
    .side_in  (g_side),
    .out_v    (r_v),
    .root     (r_root),
    .side_out (r_side)
  );

  logic                 d_v;
  logic [TAG_WIDTH-1:0] d_tag;
  logic                 d_zero;
  lane_t [LANES-1:0]    d_res;

  cotw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (r_v),
    .root     (r_root),
    .side_in  (r_side),
    .out_v    (d_v),
    .tag_out  (d_tag),
    .zero_out (d_zero),
    .res      (d_res)
  );

  logic [OUT_WIDTH-1:0] cot_nxt [LANES];
  logic [1:0]           status_nxt;

  always_comb begin
    logic [OUT_WIDTH-1:0] lim, m;
    logic                 sat, any_sat;
    any_sat = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      lim = d_res[l].neg ? MIN_MAG : MAX_POS;
      sat = d_res[l].ovf || (d_res[l].q > lim);
      m   = sat ? lim : d_res[l].q;
      any_sat    = any_sat || sat;
      cot_nxt[l] = d_zero ? '0 : (d_res[l].neg ? -m : m);
    end
    if (d_zero) begin
      status_nxt = ST_DEGEN;
    end else if (any_sat) begin
      status_nxt = ST_SAT;
    end else begin
      status_nxt = ST_OK;
    end
  end

  logic                 out_valid_r;
  logic [TAG_WIDTH-1:0] out_tag_r;
  logic [OUT_WIDTH-1:0] out_cot_r [LANES];
  logic [1:0]           out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tag_r    <= d_tag;
      out_status_r <= status_nxt;
      for (int l = 0; l < LANES; l++) begin
        out_cot_r[l] <= cot_nxt[l];
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_face_index_out = out_tag_r;
  assign out_cot_a          = out_cot_r[0];
  assign out_cot_b          = out_cot_r[1];
  assign out_cot_c          = out_cot_r[2];
  assign out_status         = out_status_r;

  // A degenerate triangle reports zero for every corner.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_DEGEN) |->
      (out_cot_a == '0 && out_cot_b == '0 && out_cot_c == '0))
    else $error("degenerate word with nonzero cotangent");

  // A saturated word carries at least one value at a range limit.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_SAT) |->
      (out_cot_a == MAX_POS || out_cot_a == MIN_MAG ||
       out_cot_b == MAX_POS || out_cot_b == MIN_MAG ||
       out_cot_c == MAX_POS || out_cot_c == MIN_MAG))
    else $error("saturated status without a limit value");

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle cotangent weights: testbench
// Streams triangles into the block and checks each result word against a
// local bit-exact model of the cotangent arithmetic, under random idling on
// both channels, a long receiver hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module testbench;
  import cotw_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 120;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct {
    logic [TAG_WIDTH-1:0] face;
    coord_t ax, ay, az, bx, by, bz, cx, cy, cz;
  } triangle_t;

  typedef struct {
    logic [TAG_WIDTH-1:0] face;
    logic [OUT_WIDTH-1:0] cot_a, cot_b, cot_c;
    status_t status;
  } weights_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [TAG_WIDTH-1:0] in_face_index = '0;
  coord_t in_ax = '0, in_ay = '0, in_az = '0;
  coord_t in_bx = '0, in_by_coord = '0, in_bz = '0;
  coord_t in_cx = '0, in_cy = '0, in_cz = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [TAG_WIDTH-1:0] out_face_index_out;
  logic signed [OUT_WIDTH-1:0] out_cot_a, out_cot_b, out_cot_c;
  logic [1:0] out_status;

  weights_t expected_weights[$];
  bit idling_on = 1'b0;
  int hold_request = 0;
  int mismatches = 0;
  int checked = 0;
  int sent = 0;
  int degenerate_seen = 0;
  int saturated_seen = 0;
  int cycles = 0;

  triangle_cotangent_weights_top dut (.*);

  initial begin
    forever begin
      #1 clk = ~clk;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding.", cycles,
               expected_weights.size());
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [OUT_WIDTH-1:0] scaled_cot(logic signed [127:0] num,
                                                      logic [127:0] den, ref bit sat);
    logic [127:0] mag, q, lim, m;
    bit neg;
    neg = num < 0;
    mag = neg ? -num : num;
    q = (mag << OUT_FRAC_BITS) / den;
    lim = neg ? (128'd1 << (OUT_WIDTH - 1)) : (128'd1 << (OUT_WIDTH - 1)) - 1;
    if (q > lim) begin
      sat = 1'b1;
      m = lim;
    end else begin
      m = q;
    end
    return neg ? OUT_WIDTH'(-m) : OUT_WIDTH'(m);
  endfunction

  function automatic weights_t predict_weights(triangle_t t);
    logic signed [127:0] ux, uy, uz, vx, vy, vz, wx, wy, wz;
    logic signed [127:0] a2, b2, c2, kx, ky, kz;
    logic [127:0] area_sq, den;
    logic [63:0] root, cand;
    bit sat;
    weights_t w;
    ux = t.bx - t.ax; uy = t.by - t.ay; uz = t.bz - t.az;
    vx = t.cx - t.ax; vy = t.cy - t.ay; vz = t.cz - t.az;
    wx = t.bx - t.cx; wy = t.by - t.cy; wz = t.bz - t.cz;
    a2 = wx * wx + wy * wy + wz * wz;
    b2 = vx * vx + vy * vy + vz * vz;
    c2 = ux * ux + uy * uy + uz * uz;
    kx = uy * vz - uz * vy;
    ky = uz * vx - ux * vz;
    kz = ux * vy - uy * vx;
    area_sq = kx * kx + ky * ky + kz * kz;
    w.face = t.face;
    if (area_sq == 0) begin
      w.cot_a = '0;
      w.cot_b = '0;
      w.cot_c = '0;
      w.status = ST_DEGEN;
      return w;
    end
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      cand = root | (64'd1 << i);
      if (128'(cand) * 128'(cand) <= area_sq) root = cand;
    end
    den = 128'(root) << 1;
    sat = 1'b0;
    w.cot_a = scaled_cot(b2 + c2 - a2, den, sat);
    w.cot_b = scaled_cot(c2 + a2 - b2, den, sat);
    w.cot_c = scaled_cot(a2 + b2 - c2, den, sat);
    w.status = sat ? ST_SAT : ST_OK;
    return w;
  endfunction

  // Result side: checks accepted words and decides the stall for the next cycle.
  initial begin
    int burst;
    int hold_left;
    weights_t w;
    burst = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        checked++;
        if (expected_weights.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result word, face %0d.", out_face_index_out);
        end else begin
          w = expected_weights.pop_front();
          if (w.status == ST_DEGEN) degenerate_seen++;
          if (w.status == ST_SAT) saturated_seen++;
          if (out_face_index_out !== w.face || out_cot_a !== w.cot_a ||
              out_cot_b !== w.cot_b || out_cot_c !== w.cot_c ||
              out_status !== w.status) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Mismatch on face %0d: expected %h %h %h status %0d",
                       w.face, w.cot_a, w.cot_b, w.cot_c, w.status);
              $display("  got face %0d: %h %h %h status %0d", out_face_index_out,
                       out_cot_a, out_cot_b, out_cot_c, out_status);
            end
          end
        end
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(0, 13);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_triangle(triangle_t t);
    in_valid <= 1'b1;
    in_face_index <= t.face;
    in_ax <= t.ax; in_ay <= t.ay; in_az <= t.az;
    in_bx <= t.bx; in_by_coord <= t.by; in_bz <= t.bz;
    in_cx <= t.cx; in_cy <= t.cy; in_cz <= t.cz;
    do @(posedge clk); while (in_stall);
    expected_weights.push_back(predict_weights(t));
    sent++;
    if (idling_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_weights.size() != 0) @(posedge clk);
  endtask

  function automatic triangle_t make_triangle(coord_t ax, coord_t ay, coord_t az,
                                              coord_t bx, coord_t by, coord_t bz,
                                              coord_t cx, coord_t cy, coord_t cz);
    triangle_t t;
    t.face = TAG_WIDTH'($urandom);
    t.ax = ax; t.ay = ay; t.az = az;
    t.bx = bx; t.by = by; t.bz = bz;
    t.cx = cx; t.cy = cy; t.cz = cz;
    return t;
  endfunction

  function automatic coord_t near(coord_t base, int spread);
    return base + coord_t'($urandom_range(0, 2 * spread) - spread);
  endfunction

  function automatic triangle_t random_triangle();
    triangle_t t;
    int spread;
    int pick;
    pick = $urandom_range(0, 9);
    t = make_triangle(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                      coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                      coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
    if (pick < 5) begin
      spread = 1 << $urandom_range(2, 16);
      t.bx = near(t.ax, spread); t.by = near(t.ay, spread); t.bz = near(t.az, spread);
      t.cx = near(t.ax, spread); t.cy = near(t.ay, spread); t.cz = near(t.az, spread);
    end else if (pick < 8) begin
      // A sliver: C sits next to the midpoint of AB, which drives saturation.
      t.cx = coord_t'((int'(t.ax) + int'(t.bx)) >>> 1);
      t.cy = near(coord_t'((int'(t.ay) + int'(t.by)) >>> 1), 2);
      t.cz = coord_t'((int'(t.az) + int'(t.bz)) >>> 1);
    end else if (pick == 8) begin
      t.cx = t.bx; t.cy = t.by; t.cz = t.bz;
    end
    return t;
  endfunction

  task automatic test_directed();
    coord_t hi, lo, one, two;
    triangle_t t;
    hi = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    lo = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    one = coord_t'(4096);
    two = coord_t'(8192);
    t = make_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0);
    t.face = '0;
    send_triangle(t);
    t = make_triangle(hi, hi, hi, hi, hi, hi, hi, hi, hi);
    t.face = '1;
    send_triangle(t);
    send_triangle(make_triangle(0, 0, 0, one, 0, 0, 0, one, 0));
    send_triangle(make_triangle(0, 0, 0, one, 0, 0, one >>> 1, 3547, 0));
    send_triangle(make_triangle(0, 0, 0, one, one, one, two, two, two));
    send_triangle(make_triangle(lo, lo, lo, hi, hi, hi, lo, hi, lo));
    send_triangle(make_triangle(hi, lo, hi, lo, hi, lo, hi, hi, lo));
    send_triangle(make_triangle(lo, 0, 0, hi, 0, 0, 0, 1, 0));
    send_triangle(make_triangle(lo, 0, 0, hi, 0, 0, 0, hi, 0));
    send_triangle(make_triangle(0, 0, 0, 1, 0, 0, 0, 1, 0));
    send_triangle(make_triangle(0, 0, lo, 0, hi, 0, hi, 0, 0));
    send_triangle(make_triangle(0, 0, 0, hi, 0, 0, hi, 1, 0));
    send_triangle(make_triangle(0, 0, 0, 0, 0, hi, 1, 0, lo));
    send_triangle(make_triangle(-1, -1, -1, 1, -1, 1, -1, 1, 1));
    wait_drained();
  endtask

  task automatic test_random_stream(int count);
    repeat (count) send_triangle(random_triangle());
  endtask

  task automatic test_backpressure();
    hold_request = 400;
    repeat (200) send_triangle(random_triangle());
  endtask

  task automatic test_drain_pause();
    wait_drained();
    repeat (5) @(posedge clk);
    test_random_stream(50);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idling_on = 1'b1;
    test_directed();
    test_random_stream(700);
    test_backpressure();
    test_drain_pause();
    test_random_stream(500);
    idling_on = 1'b0;
    test_random_stream(300);
    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d triangles and checked %0d result words (%0d degenerate, %0d saturated).",
             sent, checked, degenerate_seen, saturated_seen);
    $display("Coverage included a long output hold-off, a full drain and %0d mismatches.",
             mismatches);
    if (mismatches == 0 && expected_weights.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/cotw_pkg.sv
rtl/cotw_geom.sv
rtl/cotw_sqrt.sv
rtl/cotw_div.sv
rtl/triangle_cotangent_weights_top.sv
tb/testbench.sv
